FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge, masked while reset is active
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequence is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/c2s_pkg.sv
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared widths, constants and stage types for the cube-to-sphere projector.
// ----------------------------------------------------------------------------
package c2s_pkg;
    localparam int GridMax   = 1024;
    localparam int IdxW      = 10;
    localparam int RadW      = 16;
    localparam int StepW     = 17;
    localparam int OutW      = 25;
    localparam int CompW     = 28;  // signed Q16 component
    localparam int SumW      = 56;  // sum of squares, Q32
    localparam int RootW     = 28;  // square root, Q16
    localparam int RootSteps = 28;  // one result bit per cell
    localparam int DivW      = 45;  // dividend |c| * 2^16 + q/2
    localparam int RatW      = 18;  // quotient bits kept (ratio <= 2^17)
    localparam int PipeD     = 5 + RootSteps + RatW + 3;

    localparam logic [2:0] FaceNegZ = 3'd1;
    localparam logic [2:0] FaceNegY = 3'd2;
    localparam logic [2:0] FacePosY = 3'd3;
    localparam logic [2:0] FacePosX = 3'd4;
    localparam logic [2:0] FaceNegX = 3'd5;

    localparam logic [RootW-1:0] HalfQ16 = RootW'(32768);

    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_STEP   = 2'd1
    } cfg_reg_t;

    // Item carried through the root cells
    typedef struct packed {
        logic              vld;
        logic [2:0]        face;
        logic              u_neg;
        logic              v_neg;
        logic [RootW-1:0]  u_mag;
        logic [RootW-1:0]  v_mag;
        logic [RadW-1:0]   radius;
        logic [SumW-1:0]   rem;
        logic [RootW-1:0]  root;
    } root_item_t;

    // Item carried through the divider cells: three quotients in parallel;
    // den holds the divisor aligned to the quotient bit of the next cell
    typedef struct packed {
        logic              vld;
        logic [2:0]        face;
        logic              u_neg;
        logic              v_neg;
        logic [RadW-1:0]   radius;
        logic [DivW-1:0]   den;
        logic [DivW-1:0]   rem_u;
        logic [DivW-1:0]   rem_v;
        logic [DivW-1:0]   rem_h;
        logic [RatW-1:0]   q_u;
        logic [RatW-1:0]   q_v;
        logic [RatW-1:0]   q_h;
    } div_item_t;
endpackage

FILE: rtl/c2s_root_cell.sv
// ----------------------------------------------------------------------------
// c2s_root_cell
// One restoring square-root step: settles one result bit per cycle while en is high.
// ----------------------------------------------------------------------------
module c2s_root_cell
    import c2s_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  root_item_t in_item,
    input  logic [1:0] pair,
    output root_item_t out_item
);
    logic [SumW+1:0] trial;
    logic [SumW+1:0] rem_sh;
    root_item_t      item_next;
    root_item_t      item_reg;

    // Try root bit: rem' = rem*4 + next pair; compare with root*4+1
    always_comb begin
        rem_sh    = {in_item.rem, pair};
        trial     = {(SumW+2-RootW-2)'(0), in_item.root, 2'b01};
        item_next = in_item;
        if (rem_sh >= trial) begin
            item_next.rem  = SumW'(rem_sh - trial);
            item_next.root = {in_item.root[RootW-2:0], 1'b1};
        end else begin
            item_next.rem  = SumW'(rem_sh);
            item_next.root = {in_item.root[RootW-2:0], 1'b0};
        end
    end

    // Advance one cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.vld <= 1'b0;
        end else if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_item = item_reg;
endmodule

FILE: rtl/c2s_div_cell.sv
// ----------------------------------------------------------------------------
// c2s_div_cell
// One restoring division step for the three component ratios.
// ----------------------------------------------------------------------------
module c2s_div_cell
    import c2s_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  div_item_t in_item,
    input  logic      unused_tie,
    output div_item_t out_item
);
    div_item_t item_next;
    div_item_t item_reg;
    logic      fit_u, fit_v, fit_h;

    // Subtract the aligned divisor from each remainder when it fits,
    // shift the quotient bit in and align the divisor for the next cell
    always_comb begin
        item_next = in_item;
        fit_u     = (in_item.rem_u >= in_item.den) && !unused_tie;
        fit_v     = (in_item.rem_v >= in_item.den) && !unused_tie;
        fit_h     = (in_item.rem_h >= in_item.den) && !unused_tie;
        if (fit_u) item_next.rem_u = in_item.rem_u - in_item.den;
        if (fit_v) item_next.rem_v = in_item.rem_v - in_item.den;
        if (fit_h) item_next.rem_h = in_item.rem_h - in_item.den;
        item_next.q_u = {in_item.q_u[RatW-2:0], fit_u};
        item_next.q_v = {in_item.q_v[RatW-2:0], fit_v};
        item_next.q_h = {in_item.q_h[RatW-2:0], fit_h};
        item_next.den = in_item.den >> 1;
    end

    // Advance one cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.vld <= 1'b0;
        end else if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_item = item_reg;
endmodule

FILE: rtl/cube_to_sphere_vertex.sv
// Structure: 5 setup stages, 28 square-root cells, 18 divider cells and 3 scale
//   stages lie between input accept and result valid.
// Throughput: one item per cycle; the whole cell chain advances together
//   and stalls only while the output holds an untaken item.
// Reset: aresetn synchronous, active low; clears all valid bits and loads
//   radius = 1024 and step_size = 65536.
// ----------------------------------------------------------------------------
// cube_to_sphere_vertex
// Projects a cube-face grid point onto a sphere through a chain of cells.
// ----------------------------------------------------------------------------
module cube_to_sphere_vertex
    import c2s_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // grid_col[9:0], grid_row[19:10], face[22:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // pos_x[24:0], pos_y[49:25], pos_z[74:50]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    logic en;
    logic [RadW-1:0]  radius_reg;
    logic [StepW-1:0] step_reg;

    assign cfg_ready = 1'b1;
    // Whole chain advances unless the last result is stalled
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;

    // Hold configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RadW'(1024);
            step_reg   <= StepW'(65536);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_data[RadW-1:0];
                REG_STEP:   step_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Stage 1: clamp not needed (10-bit index max 1023), form products
    logic              s1_vld_reg;
    logic [2:0]        s1_face_reg;
    logic [RadW-1:0]   s1_rad_reg;
    logic [26:0]       s1_cs_reg, s1_rs_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) s1_vld_reg <= 1'b0;
        else if (en) s1_vld_reg <= s_tvalid;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_face_reg <= s_tdata[22:20];
            s1_rad_reg  <= radius_reg;
            s1_cs_reg   <= 27'(s_tdata[9:0] * step_reg);
            s1_rs_reg   <= 27'(s_tdata[19:10] * step_reg);
        end
    end

    // Stage 2: signed components as sign and magnitude
    logic              s2_vld_reg;
    logic [2:0]        s2_face_reg;
    logic [RadW-1:0]   s2_rad_reg;
    logic              s2_un_reg, s2_vn_reg;
    logic [RootW-1:0]  s2_um_reg, s2_vm_reg;
    logic [RootW-1:0]  cs_ext, rs_ext;
    assign cs_ext = RootW'(s1_cs_reg);
    assign rs_ext = RootW'(s1_rs_reg);
    always_ff @(posedge aclk) begin
        if (!aresetn) s2_vld_reg <= 1'b0;
        else if (en) s2_vld_reg <= s1_vld_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            s2_face_reg <= s1_face_reg;
            s2_rad_reg  <= s1_rad_reg;
            s2_un_reg   <= cs_ext < HalfQ16;
            s2_um_reg   <= (cs_ext < HalfQ16) ? HalfQ16 - cs_ext : cs_ext - HalfQ16;
            s2_vn_reg   <= rs_ext > HalfQ16;
            s2_vm_reg   <= (rs_ext > HalfQ16) ? rs_ext - HalfQ16 : HalfQ16 - rs_ext;
        end
    end

    // Stage 3: squares, split into low and high halves
    logic              s3_vld_reg;
    logic [2:0]        s3_face_reg;
    logic [RadW-1:0]   s3_rad_reg;
    logic              s3_un_reg, s3_vn_reg;
    logic [RootW-1:0]  s3_um_reg, s3_vm_reg;
    logic [SumW-1:0]   s3_uu_reg, s3_vv_reg;
    logic [SumW-1:0]   uu_lo, uu_hi, vv_lo, vv_hi;
    always_ff @(posedge aclk) begin
        if (!aresetn) s3_vld_reg <= 1'b0;
        else if (en) s3_vld_reg <= s2_vld_reg;
    end
    // Cross products kept within 28x14-bit pieces
    assign uu_lo = SumW'(s2_um_reg * s2_um_reg[13:0]);
    assign uu_hi = SumW'(s2_um_reg * s2_um_reg[27:14]) << 14;
    assign vv_lo = SumW'(s2_vm_reg * s2_vm_reg[13:0]);
    assign vv_hi = SumW'(s2_vm_reg * s2_vm_reg[27:14]) << 14;
    always_ff @(posedge aclk) begin
        if (en) begin
            s3_face_reg <= s2_face_reg;
            s3_rad_reg  <= s2_rad_reg;
            s3_un_reg   <= s2_un_reg;
            s3_vn_reg   <= s2_vn_reg;
            s3_um_reg   <= s2_um_reg;
            s3_vm_reg   <= s2_vm_reg;
            s3_uu_reg   <= uu_lo + uu_hi;
            s3_vv_reg   <= vv_lo + vv_hi;
        end
    end

    // Stage 4: sum of squares plus h^2
    logic              s4_vld_reg;
    logic [2:0]        s4_face_reg;
    logic [RadW-1:0]   s4_rad_reg;
    logic              s4_un_reg, s4_vn_reg;
    logic [RootW-1:0]  s4_um_reg, s4_vm_reg;
    logic [SumW-1:0]   s4_sum_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) s4_vld_reg <= 1'b0;
        else if (en) s4_vld_reg <= s3_vld_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            s4_face_reg <= s3_face_reg;
            s4_rad_reg  <= s3_rad_reg;
            s4_un_reg   <= s3_un_reg;
            s4_vn_reg   <= s3_vn_reg;
            s4_um_reg   <= s3_um_reg;
            s4_vm_reg   <= s3_vm_reg;
            s4_sum_reg  <= s3_uu_reg + s3_vv_reg + (SumW'(1) << 30);
        end
    end

    // Stage 5: load root chain head
    root_item_t root_head_reg;
    logic [SumW-1:0] sum_pipe_reg [RootSteps];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_head_reg.vld <= 1'b0;
        end else if (en) begin
            root_head_reg.vld    <= s4_vld_reg;
            root_head_reg.face   <= s4_face_reg;
            root_head_reg.u_neg  <= s4_un_reg;
            root_head_reg.v_neg  <= s4_vn_reg;
            root_head_reg.u_mag  <= s4_um_reg;
            root_head_reg.v_mag  <= s4_vm_reg;
            root_head_reg.radius <= s4_rad_reg;
            root_head_reg.rem    <= '0;
            root_head_reg.root   <= '0;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) sum_pipe_reg[0] <= s4_sum_reg;
    end

    // Square-root chain, most significant pair first
    root_item_t root_link [RootSteps+1];
    assign root_link[0] = root_head_reg;
    for (genvar i = 0; i < RootSteps; i++) begin : g_root
        c2s_root_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_item (root_link[i]),
            .pair    (sum_pipe_reg[i][2*(RootSteps-1-i)+1 -: 2]),
            .out_item(root_link[i+1])
        );
        if (i < RootSteps-1) begin : g_sum
            always_ff @(posedge aclk) begin
                if (en) sum_pipe_reg[i+1] <= sum_pipe_reg[i];
            end
        end
    end

    // Divider chain head: dividends |c|*2^16 + q/2
    root_item_t rt;
    div_item_t  div_head;
    logic [RootW-1:0] qd;
    assign rt = root_link[RootSteps];
    assign qd = (rt.root == '0) ? RootW'(1) : rt.root;
    always_comb begin
        div_head.vld    = rt.vld;
        div_head.face   = rt.face;
        div_head.u_neg  = rt.u_neg;
        div_head.v_neg  = rt.v_neg;
        div_head.radius = rt.radius;
        div_head.den    = DivW'(qd) << (RatW-1);
        div_head.rem_u  = ({DivW'(rt.u_mag)} << 16) + DivW'(qd >> 1);
        div_head.rem_v  = ({DivW'(rt.v_mag)} << 16) + DivW'(qd >> 1);
        div_head.rem_h  = ({DivW'(HalfQ16)} << 16) + DivW'(qd >> 1);
        div_head.q_u    = '0;
        div_head.q_v    = '0;
        div_head.q_h    = '0;
    end

    // Division chain; quotient never exceeds 2^18 since c <= 4q (well below)
    div_item_t div_link [RatW+1];
    assign div_link[0] = div_head;
    for (genvar j = 0; j < RatW; j++) begin : g_div
        c2s_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_item   (div_link[j]),
            .unused_tie(1'b0),
            .out_item  (div_link[j+1])
        );
    end

    // Scale stage A: clamp ratios
    div_item_t dt;
    assign dt = div_link[RatW];
    logic              a_vld_reg;
    logic [2:0]        a_face_reg;
    logic              a_un_reg, a_vn_reg;
    logic [RadW-1:0]   a_rad_reg;
    logic [16:0]       a_ru_reg, a_rv_reg, a_rh_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) a_vld_reg <= 1'b0;
        else if (en) a_vld_reg <= dt.vld;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            a_face_reg <= dt.face;
            a_un_reg   <= dt.u_neg;
            a_vn_reg   <= dt.v_neg;
            a_rad_reg  <= dt.radius;
            a_ru_reg   <= (dt.q_u > RatW'(65536)) ? 17'd65536 : dt.q_u[16:0];
            a_rv_reg   <= (dt.q_v > RatW'(65536)) ? 17'd65536 : dt.q_v[16:0];
            a_rh_reg   <= (dt.q_h > RatW'(65536)) ? 17'd65536 : dt.q_h[16:0];
        end
    end

    // Scale stage B: multiply by radius and round to Q8
    logic              b_vld_reg;
    logic [2:0]        b_face_reg;
    logic              b_un_reg, b_vn_reg;
    logic [OutW-1:0]   b_mu_reg, b_mv_reg, b_mh_reg;
    logic [32:0]       pu, pv, ph;
    assign pu = 33'(a_ru_reg * a_rad_reg) + 33'd128;
    assign pv = 33'(a_rv_reg * a_rad_reg) + 33'd128;
    assign ph = 33'(a_rh_reg * a_rad_reg) + 33'd128;
    always_ff @(posedge aclk) begin
        if (!aresetn) b_vld_reg <= 1'b0;
        else if (en) b_vld_reg <= a_vld_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            b_face_reg <= a_face_reg;
            b_un_reg   <= a_un_reg;
            b_vn_reg   <= a_vn_reg;
            b_mu_reg   <= pu[OutW+7:8];
            b_mv_reg   <= pv[OutW+7:8];
            b_mh_reg   <= ph[OutW+7:8];
        end
    end

    // Output stage: apply signs and place on axes
    logic [OutW-1:0] su, sv, sh, snh, ox, oy, oz;
    assign su  = b_un_reg ? OutW'(-b_mu_reg) : b_mu_reg;
    assign sv  = b_vn_reg ? OutW'(-b_mv_reg) : b_mv_reg;
    assign sh  = b_mh_reg;
    assign snh = OutW'(-b_mh_reg);
    always_comb begin
        case (b_face_reg)
            FaceNegZ: begin ox = su;  oy = sv;  oz = snh; end
            FaceNegY: begin ox = su;  oy = snh; oz = sv;  end
            FacePosY: begin ox = su;  oy = sh;  oz = sv;  end
            FacePosX: begin ox = sh;  oy = su;  oz = sv;  end
            FaceNegX: begin ox = snh; oy = su;  oz = sv;  end
            default:  begin ox = su;  oy = sv;  oz = sh;  end
        endcase
    end

    logic            out_vld_reg;
    logic [79:0]     out_data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) out_vld_reg <= 1'b0;
        else if (en) out_vld_reg <= b_vld_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) out_data_reg <= {5'd0, oz, oy, ox};
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
endmodule

FILE: rtl/c2s_checker.sv
// ----------------------------------------------------------------------------
// c2s_checker
// Port-level checks for the cube-to-sphere projector.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module c2s_checker
    import c2s_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic        cfg_ready
);
    // Stalled result holds
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && m_tvalid, "result changed while stalled")
    // Input is taken whenever output side is free
    `ASSERT_IMPLIES(a_ready, aclk, aresetn, !m_tvalid || m_tready, s_tready, "input blocked with free output")
    // Stall on output stalls input
    `ASSERT_IMPLIES(a_stall, aclk, aresetn, m_tvalid && !m_tready, !s_tready, "input taken during stall")
    // Padding bits stay zero
    `ASSERT_IMPLIES(a_pad, aclk, aresetn, m_tvalid, m_tdata[79:75] == 5'd0, "padding bits set")
    // Configuration always accepted
    `ASSERT_IMPLIES(a_cfg, aclk, aresetn, 1'b1, cfg_ready, "config not ready")
endmodule

bind cube_to_sphere_vertex c2s_checker u_c2s_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_ready(cfg_ready)
);
